@@ hw/rtl/mrre_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrre_pkg
// Shared types and constants of the mask row run extractor.
// ----------------------------------------------------------------------------
package mrre_pkg;

    localparam int NUM_LANES = 8;
    localparam int NUM_POS   = NUM_LANES + 1;
    localparam int LANE_IDX_W = 4;

    localparam int X_W       = 12;
    localparam int ROW_OUT_W = 12;
    localparam int LEN_W     = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MASK_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_HEIGHT = 2'd1;

    // what one lane reports about the boundary in front of its pixel
    typedef struct packed {
        logic             close;
        logic [X_W-1:0]   x;
        logic [LEN_W-1:0] len;
    } mrre_lane_t;

endpackage
`default_nettype wire

@@ hw/rtl/mrre_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrre_lane
// One pixel position of the byte: decides whether a run closes in front of
// this position and works out that run's start column and length.
// ----------------------------------------------------------------------------
module mrre_lane #(
    parameter int COL_W = 13
) (
    input  wire logic [mrre_pkg::LANE_IDX_W-1:0] lane_idx,
    input  wire logic [mrre_pkg::NUM_LANES-1:0]  vb,
    input  wire logic                            run_open,
    input  wire logic [mrre_pkg::X_W-1:0]        open_start,
    input  wire logic [mrre_pkg::LEN_W-1:0]      open_length,
    input  wire logic [COL_W-1:0]                col,
    input  wire logic                            row_end,
    output mrre_pkg::mrre_lane_t                 res
);

    logic [mrre_pkg::NUM_POS-1:0]    prev_bits;
    logic                            cur_clear;
    logic [mrre_pkg::LANE_IDX_W-1:0] start_lane;
    logic                            found;
    logic                            from_open;

    // prev_bits[k] is the pixel left of lane k, the open run for lane zero
    assign prev_bits = {vb, run_open};

    always_comb
    begin
        if (lane_idx == mrre_pkg::LANE_IDX_W'(mrre_pkg::NUM_LANES))
            cur_clear = row_end;
        else
            cur_clear = !vb[lane_idx[2:0]];
    end

    // nearest clear pixel to the left bounds the run
    always_comb
    begin
        start_lane = '0;
        found      = 1'b0;
        for (int j = 0; j < mrre_pkg::NUM_LANES; j++)
        begin
            if ((mrre_pkg::LANE_IDX_W'(j) < lane_idx) && !vb[j])
            begin
                start_lane = mrre_pkg::LANE_IDX_W'(j + 1);
                found      = 1'b1;
            end
        end
    end

    assign from_open = !found && run_open;

    always_comb
    begin
        res.close = prev_bits[lane_idx] && cur_clear;
        if (from_open)
        begin
            res.x   = open_start;
            res.len = open_length + mrre_pkg::LEN_W'(lane_idx);
        end
        else
        begin
            res.x   = mrre_pkg::X_W'(col + COL_W'(start_lane));
            res.len = mrre_pkg::LEN_W'(lane_idx) - mrre_pkg::LEN_W'(start_lane);
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/mrre_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrre_merge
// Holds the runs that one byte closed and hands them out one per cycle while
// out_ready is high, left to right, marking the last one of the byte.
// ----------------------------------------------------------------------------
module mrre_merge (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire mrre_pkg::mrre_lane_t               lane_res [mrre_pkg::NUM_POS],
    input  wire logic [mrre_pkg::ROW_OUT_W-1:0]     load_row,
    output logic                                    can_load,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [mrre_pkg::X_W-1:0]                run_x,
    output logic [mrre_pkg::ROW_OUT_W-1:0]          run_row,
    output logic [mrre_pkg::LEN_W-1:0]              run_length,
    output logic                                    last_of_burst
);

    logic [mrre_pkg::NUM_POS-1:0]   pend_reg;
    logic [mrre_pkg::NUM_POS-1:0]   pend_next;
    logic [mrre_pkg::NUM_POS-1:0]   pend_after;
    logic [mrre_pkg::NUM_POS-1:0]   pick;
    logic [mrre_pkg::NUM_POS-1:0]   load_mask;
    mrre_pkg::mrre_lane_t           ent_reg [mrre_pkg::NUM_POS];
    logic [mrre_pkg::ROW_OUT_W-1:0] row_reg;
    logic                           fire;

    // lowest pending slot is the leftmost run still to send
    assign pick          = pend_reg & (~pend_reg + mrre_pkg::NUM_POS'(1));
    assign out_valid     = |pend_reg;
    assign last_of_burst = (pend_reg & (pend_reg - mrre_pkg::NUM_POS'(1))) == '0;
    assign fire          = out_valid && out_ready;
    assign pend_after    = fire ? (pend_reg & ~pick) : pend_reg;
    assign can_load      = (pend_after == '0);

    always_comb
    begin
        for (int i = 0; i < mrre_pkg::NUM_POS; i++)
            load_mask[i] = lane_res[i].close;
        pend_next = load ? load_mask : pend_after;
    end

    always_comb
    begin
        run_x      = '0;
        run_length = '0;
        for (int i = 0; i < mrre_pkg::NUM_POS; i++)
        begin
            if (pick[i])
            begin
                run_x      = run_x | ent_reg[i].x;
                run_length = run_length | ent_reg[i].len;
            end
        end
        run_row = row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= lane_res;
            row_reg <= load_row;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/mask_row_run_extractor_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mask_row_run_extractor_top
// Horizontal run extraction from a one-bit mask streamed a byte at a time.
// ----------------------------------------------------------------------------
// Mask bytes enter on in_valid/in_ready, rows top first, ceil(width/8) bytes
// per row, bit 7 leftmost. Each run of set pixels leaves on out_valid/out_ready
// as (run_x, run_row, run_length) once a clear pixel or the row end closes it;
// last_of_burst marks the final run caused by one byte.
// Eight lanes examine the byte's pixels side by side and a ninth checks the
// row end, so a transaction is taken every cycle unless earlier runs wait to
// be sent. Runs appear in the cycle after the byte is accepted. A byte closing
// n runs holds the output until all n are sent; the next byte is taken in the
// cycle its last run is sent, so bytes with at most one run stream at one per
// cycle while the receiver is ready. A stalled receiver holds the current run
// and blocks input while any run is pending.
// The cfg channel (cfg_index 0 width, 1 height) is always ready and should be
// written only while idle. Reset sets width and height to 64, the position to
// the top left corner and drops any open run.
// ----------------------------------------------------------------------------
module mask_row_run_extractor_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          mask_byte,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [mrre_pkg::X_W-1:0]                 run_x,
    output logic [mrre_pkg::ROW_OUT_W-1:0]           run_row,
    output logic [mrre_pkg::LEN_W-1:0]               run_length,
    output logic                                     last_of_burst,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mrre_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mrre_pkg::CFG_W-1:0]          cfg_data
);

    localparam int CFG_MAX = (1 << mrre_pkg::CFG_W) - 1;
    localparam int W_CAP   = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
    localparam int H_CAP   = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
    localparam int COL_W   = $clog2(W_CAP + mrre_pkg::NUM_LANES);
    localparam int ROW_W   = $clog2(H_CAP + 1);
    localparam int RESET_W = (64 > W_CAP) ? W_CAP : 64;
    localparam int RESET_H = (64 > H_CAP) ? H_CAP : 64;

    logic [COL_W-1:0]             width_reg;
    logic [ROW_W-1:0]             height_reg;
    logic [COL_W-1:0]             width_cfg;
    logic [ROW_W-1:0]             height_cfg;
    logic [COL_W-1:0]             col_reg;
    logic [COL_W-1:0]             col_next;
    logic [ROW_W-1:0]             row_reg;
    logic [ROW_W-1:0]             row_next;
    logic [ROW_W-1:0]             row_inc;
    logic                         open_reg;
    logic                         open_next;
    logic [mrre_pkg::X_W-1:0]     start_reg;
    logic [mrre_pkg::LEN_W-1:0]   length_reg;
    logic [mrre_pkg::NUM_LANES-1:0] vb;
    logic                         row_end;
    logic                         in_fire;
    logic                         cfg_fire;
    mrre_pkg::mrre_lane_t         lane_res [mrre_pkg::NUM_POS];

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;

    // zero acts as one, oversize clamps to the largest supported size
    always_comb
    begin
        if (cfg_data == '0)
            width_cfg = COL_W'(1);
        else if ({1'b0, cfg_data} > (mrre_pkg::CFG_W + 1)'(W_CAP))
            width_cfg = COL_W'(W_CAP);
        else
            width_cfg = COL_W'(cfg_data);

        if (cfg_data == '0)
            height_cfg = ROW_W'(1);
        else if ({1'b0, cfg_data} > (mrre_pkg::CFG_W + 1)'(H_CAP))
            height_cfg = ROW_W'(H_CAP);
        else
            height_cfg = ROW_W'(cfg_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= COL_W'(RESET_W);
            height_reg <= ROW_W'(RESET_H);
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                mrre_pkg::REG_MASK_WIDTH:  width_reg  <= width_cfg;
                mrre_pkg::REG_MASK_HEIGHT: height_reg <= height_cfg;
                default: ;
            endcase
        end
    end

    // pixels at or past the width are treated as clear
    always_comb
    begin
        for (int j = 0; j < mrre_pkg::NUM_LANES; j++)
            vb[j] = mask_byte[7 - j] && ((col_reg + COL_W'(j)) < width_reg);
    end

    assign row_end = (col_reg + COL_W'(mrre_pkg::NUM_LANES)) >= width_reg;

    for (genvar g = 0; g < mrre_pkg::NUM_POS; g++)
    begin : g_lane
        mrre_lane #(
            .COL_W       (COL_W)
        ) u_lane (
            .lane_idx    (mrre_pkg::LANE_IDX_W'(g)),
            .vb          (vb),
            .run_open    (open_reg),
            .open_start  (start_reg),
            .open_length (length_reg),
            .col         (col_reg),
            .row_end     (row_end),
            .res         (lane_res[g])
        );
    end

    assign row_inc   = row_reg + ROW_W'(1);
    assign col_next  = row_end ? '0 : col_reg + COL_W'(mrre_pkg::NUM_LANES);
    assign open_next = !row_end && vb[mrre_pkg::NUM_LANES-1];

    always_comb
    begin
        row_next = row_reg;
        if (row_end)
            row_next = (row_inc >= height_reg) ? '0 : row_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            open_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            open_reg <= open_next;
        end
    end

    // the row-end lane also describes the run carried into the next byte
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            start_reg  <= lane_res[mrre_pkg::NUM_LANES].x;
            length_reg <= lane_res[mrre_pkg::NUM_LANES].len;
        end
    end

    mrre_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (in_fire),
        .lane_res      (lane_res),
        .load_row      (mrre_pkg::ROW_OUT_W'(row_reg)),
        .can_load      (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .run_x         (run_x),
        .run_row       (run_row),
        .run_length    (run_length),
        .last_of_burst (last_of_burst)
    );

endmodule
`default_nettype wire
